FILE: rtl/llg_pkg.sv
// Package for the magnetization cell update: constants, types and arithmetic helpers.
package llg_pkg;

  localparam int DATA_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int COEF_BITS      = 48;
  localparam int FACE_BITS      = 2;
  localparam int PADDR_BITS     = 5;

  // Register indexes; each register sits at byte address 8*index.
  localparam logic [1:0] IDX_FACE = 2'd0;
  localparam logic [1:0] IDX_KP   = 2'd1;
  localparam logic [1:0] IDX_KD   = 2'd2;

  localparam logic [FACE_BITS-1:0] FACE_X = 2'd0;
  localparam logic [FACE_BITS-1:0] FACE_Y = 2'd1;

  // Coefficient set shared by every update stage.
  typedef struct packed {
    logic [FACE_BITS-1:0]        face;
    logic signed [COEF_BITS-1:0] kp;
    logic signed [COEF_BITS-1:0] kd;
  } coef_t;

  // Clamp a 128-bit value to signed 64 bits.
  function automatic logic signed [63:0] sat64(input logic signed [127:0] v);
    logic signed [63:0] r;
    if (v > 128'sh0000_0000_0000_0000_7fff_ffff_ffff_ffff)
      r = 64'sh7fff_ffff_ffff_ffff;
    else if (v < -128'sh0000_0000_0000_0000_8000_0000_0000_0000)
      r = 64'sh8000_0000_0000_0000;
    else
      r = v[63:0];
    return r;
  endfunction

endpackage

FILE: rtl/llg_field.sv
// Field assembly stage: average the transverse samples and place H by face.
module llg_field
  import llg_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  logic [FACE_BITS-1:0]         face,
  input  logic signed [DATA_WIDTH-1:0] hc,
  input  logic signed [DATA_WIDTH-1:0] s1 [4],
  input  logic signed [DATA_WIDTH-1:0] s2 [4],
  output logic signed [DATA_WIDTH-1:0] h [3]
);
  logic signed [DATA_WIDTH+1:0] sum1, sum2;
  logic signed [DATA_WIDTH-1:0] a1, a2;

  assign sum1 = (DATA_WIDTH+2)'(s1[0]) + (DATA_WIDTH+2)'(s1[1])
              + (DATA_WIDTH+2)'(s1[2]) + (DATA_WIDTH+2)'(s1[3]);
  assign sum2 = (DATA_WIDTH+2)'(s2[0]) + (DATA_WIDTH+2)'(s2[1])
              + (DATA_WIDTH+2)'(s2[2]) + (DATA_WIDTH+2)'(s2[3]);
  assign a1 = sum1[DATA_WIDTH+1:2];
  assign a2 = sum2[DATA_WIDTH+1:2];

  always_comb begin
    if (face == FACE_X) begin
      h[0] = hc; h[1] = a1; h[2] = a2;
    end else if (face == FACE_Y) begin
      h[0] = a1; h[1] = hc; h[2] = a2;
    end else begin
      h[0] = a1; h[1] = a2; h[2] = hc;
    end
  end
endmodule

FILE: rtl/llg_comp.sv
// One component update: p = m x H, q_i = (m x p)_i, m_i += (kp*p_i + kd*q_i) >> 64.
// Five register stages inside plus the output register; m, H and valid travel alongside.
module llg_comp
  import llg_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  parameter int IDX        = 0
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  coef_t                        coef,
  input  logic                         in_valid,
  input  logic signed [DATA_WIDTH-1:0] m_in [3],
  input  logic signed [DATA_WIDTH-1:0] h_in [3],
  output logic                         out_valid,
  output logic signed [DATA_WIDTH-1:0] m_out [3],
  output logic signed [DATA_WIDTH-1:0] h_out [3]
);
  localparam int J  = (IDX + 1) % 3;
  localparam int K  = (IDX + 2) % 3;
  localparam int NS = 5;               // stages ahead of the output register
  localparam int KH = COEF_BITS - 32;  // upper coefficient slice

  logic [NS-1:0] vld;
  logic signed [DATA_WIDTH-1:0] ms [NS][3];
  logic signed [DATA_WIDTH-1:0] hs [NS][3];

  // stage 1: cross product components
  logic signed [63:0] pc [3];
  logic signed [63:0] p1 [3];
  always_comb begin
    for (int n = 0; n < 3; n++) begin
      pc[n] = sat64(((128'(m_in[(n+1)%3]) * 128'(h_in[(n+2)%3]))
                   - (128'(m_in[(n+2)%3]) * 128'(h_in[(n+1)%3]))) >>> FRAC_BITS);
    end
  end

  // stage 2: partial products of m x p, p split into halves
  logic signed [31:0] pj_hi, pk_hi;
  logic signed [32:0] pj_lo, pk_lo;
  logic signed [DATA_WIDTH+31:0] qa_hi2, qb_hi2;
  logic signed [DATA_WIDTH+32:0] qa_lo2, qb_lo2;
  logic signed [63:0] pi2;
  assign pj_hi = p1[J][63:32];
  assign pk_hi = p1[K][63:32];
  assign pj_lo = {1'b0, p1[J][31:0]};
  assign pk_lo = {1'b0, p1[K][31:0]};

  // stage 3: combine halves into q
  logic signed [127:0] qd;
  logic signed [63:0]  q3, pi3;
  assign qd = ((128'(qa_hi2) <<< 32) + 128'(qa_lo2))
            - ((128'(qb_hi2) <<< 32) + 128'(qb_lo2));

  // stage 4: coefficient partial products
  logic signed [31:0]   p_hi, q_hi;
  logic signed [32:0]   p_lo, q_lo, kp_lo, kd_lo;
  logic signed [KH-1:0] kp_hi, kd_hi;
  logic signed [65:0]   kp_ll4, kd_ll4;
  logic signed [64:0]   kp_lh4, kd_lh4;
  logic signed [KH+32:0] kp_hl4, kd_hl4;
  logic signed [KH+31:0] kp_hh4, kd_hh4;
  assign p_hi  = pi3[63:32];
  assign p_lo  = {1'b0, pi3[31:0]};
  assign q_hi  = q3[63:32];
  assign q_lo  = {1'b0, q3[31:0]};
  assign kp_hi = coef.kp[COEF_BITS-1:32];
  assign kp_lo = {1'b0, coef.kp[31:0]};
  assign kd_hi = coef.kd[COEF_BITS-1:32];
  assign kd_lo = {1'b0, coef.kd[31:0]};

  // stage 5: sum of the partial products
  logic signed [127:0] accc, acc5;
  assign accc = (128'(kp_hh4) <<< 64) + (128'(kp_hl4) <<< 32) + (128'(kp_lh4) <<< 32)
              + 128'(kp_ll4)
              + (128'(kd_hh4) <<< 64) + (128'(kd_hl4) <<< 32) + (128'(kd_lh4) <<< 32)
              + 128'(kd_ll4);

  logic signed [63:0]  delta;
  logic signed [64:0]  sum;
  logic signed [DATA_WIDTH-1:0] mnew;
  localparam logic signed [64:0] HI = 65'sd1 <<< (DATA_WIDTH-1);
  always_comb begin
    delta = sat64(acc5 >>> 64);
    sum   = 65'(ms[NS-1][IDX]) + 65'(delta);
    if (sum > HI - 65'sd1)  mnew = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    else if (sum < -HI)     mnew = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    else                    mnew = sum[DATA_WIDTH-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      vld <= {vld[NS-2:0], in_valid};
      out_valid <= vld[NS-1];
    end
    if (en) begin
      ms[0] <= m_in; hs[0] <= h_in;
      for (int s = 1; s < NS; s++) begin
        ms[s] <= ms[s-1]; hs[s] <= hs[s-1];
      end
      p1 <= pc;
      pi2 <= p1[IDX];
      qa_hi2 <= ms[0][J] * pk_hi;
      qa_lo2 <= ms[0][J] * pk_lo;
      qb_hi2 <= ms[0][K] * pj_hi;
      qb_lo2 <= ms[0][K] * pj_lo;
      q3  <= sat64(qd >>> FRAC_BITS);
      pi3 <= pi2;
      kp_ll4 <= kp_lo * p_lo;
      kp_lh4 <= kp_lo * p_hi;
      kp_hl4 <= kp_hi * p_lo;
      kp_hh4 <= kp_hi * p_hi;
      kd_ll4 <= kd_lo * q_lo;
      kd_lh4 <= kd_lo * q_hi;
      kd_hl4 <= kd_hi * q_lo;
      kd_hh4 <= kd_hi * q_hi;
      acc5 <= accc;
      h_out <= hs[NS-1];
      for (int n = 0; n < 3; n++) m_out[n] <= (n == IDX) ? mnew : ms[NS-1][n];
    end
  end
endmodule

FILE: rtl/llg_magnetization_cell_update.sv
// Top level of the pipelined LLG magnetization cell update.
// Channel  | Dir | Payload
// s_axis   | in  | tdata: mag_x..z, field_collocated, first_sample_a..d, second_sample_a..d
// m_axis   | out | tdata: new_mag_x, new_mag_y, new_mag_z
// apb      | in  | face @0x00, coef_precession @0x08, coef_damping @0x10 (64-bit data)
// One word per cycle sustained while m_axis takes every word; 19 register stages (1 field
// stage, 6 per component, the last of component z being the output register). The whole
// pipeline advances when the output word is taken or absent; a stall holds every stage,
// so nothing is lost or repeated. Reset (rst, synchronous) clears valids and the face
// and coefficient registers. Coefficients are 48 bits at 8*i.
module llg_magnetization_cell_update
  import llg_pkg::*;
#(
  parameter int DATA_WIDTH = DATA_WIDTH_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_axis_tvalid,
  output logic                    s_axis_tready,
  // fields low to high: mag_x, mag_y, mag_z, field_collocated, first_sample_a..d,
  // second_sample_a..d
  input  logic [12*DATA_WIDTH-1:0] s_axis_tdata,
  output logic                    m_axis_tvalid,
  input  logic                    m_axis_tready,
  // fields low to high: new_mag_x, new_mag_y, new_mag_z
  output logic [3*DATA_WIDTH-1:0] m_axis_tdata,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [PADDR_BITS-1:0]   paddr,
  input  logic [63:0]             pwdata,
  output logic [63:0]             prdata,
  output logic                    pready
);
  coef_t coef;
  logic  en, wr;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;

  // registers at 8*i on the 64-bit bus
  always_ff @(posedge clk) begin
    if (rst) begin
      coef <= '0;
    end else if (wr) begin
      unique case (paddr[PADDR_BITS-1:3])
        IDX_FACE: coef.face <= pwdata[FACE_BITS-1:0];
        IDX_KP:   coef.kp   <= pwdata[COEF_BITS-1:0];
        IDX_KD:   coef.kd   <= pwdata[COEF_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[PADDR_BITS-1:3])
      IDX_FACE: prdata = 64'(coef.face);
      IDX_KP:   prdata = 64'(unsigned'(coef.kp));
      IDX_KD:   prdata = 64'(unsigned'(coef.kd));
      default:  prdata = '0;
    endcase
  end

  // advance whenever the output slot is free or being drained
  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  logic signed [DATA_WIDTH-1:0] s1 [4], s2 [4], hf [3];
  logic signed [DATA_WIDTH-1:0] m0 [3], h0 [3], mi [3];
  logic v0;
  for (genvar g = 0; g < 4; g++) begin : g_s
    assign s1[g] = s_axis_tdata[(4+g)*DATA_WIDTH +: DATA_WIDTH];
    assign s2[g] = s_axis_tdata[(8+g)*DATA_WIDTH +: DATA_WIDTH];
  end
  for (genvar g = 0; g < 3; g++) begin : g_m
    assign mi[g] = s_axis_tdata[g*DATA_WIDTH +: DATA_WIDTH];
  end

  llg_field #(.DATA_WIDTH(DATA_WIDTH)) u_field (
    .face(coef.face), .hc(s_axis_tdata[3*DATA_WIDTH +: DATA_WIDTH]),
    .s1(s1), .s2(s2), .h(hf)
  );

  always_ff @(posedge clk) begin
    if (rst) v0 <= 1'b0;
    else if (en) v0 <= s_axis_tvalid;
    if (en) begin
      m0 <= mi; h0 <= hf;
    end
  end

  logic signed [DATA_WIDTH-1:0] mc [4][3], hc [4][3];
  logic vc [4];
  assign mc[0] = m0; assign hc[0] = h0; assign vc[0] = v0;

  for (genvar g = 0; g < 3; g++) begin : g_comp
    llg_comp #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS), .IDX(g)) u_comp (
      .clk(clk), .rst(rst), .en(en), .coef(coef),
      .in_valid(vc[g]), .m_in(mc[g]), .h_in(hc[g]),
      .out_valid(vc[g+1]), .m_out(mc[g+1]), .h_out(hc[g+1])
    );
  end

  assign m_axis_tvalid = vc[3];
  assign m_axis_tdata  = {mc[3][2], mc[3][1], mc[3][0]};

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_face: assert property (@(posedge clk) disable iff (rst)
    wr && paddr[PADDR_BITS-1:3] == IDX_FACE |=> coef.face == $past(pwdata[FACE_BITS-1:0]))
    else $error("face register not written");
endmodule

FILE: dv/tb.sv
// Self-checking testbench for the LLG magnetization cell update block.
`timescale 1ns / 1ps

module tb
  import llg_pkg::*;
();

  localparam int DW = 32;
  localparam int FB = 16;
  localparam int LATENCY = 19;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam logic [4:0] REG_FACE = 5'd0;
  localparam logic [4:0] REG_KP   = 5'd8;
  localparam logic [4:0] REG_KD   = 5'd16;
  localparam logic [1:0] FACE_Z   = 2'd2;

  typedef logic signed [63:0] s64_t;
  typedef logic signed [127:0] s128_t;

  logic clk;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // fields low to high: mag_x, mag_y, mag_z, field_collocated, first_sample_a..d,
  // second_sample_a..d
  logic [12*DW-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // fields low to high: new_mag_x, new_mag_y, new_mag_z
  logic [3*DW-1:0] m_axis_tdata;
  logic psel, penable, pwrite;
  logic [4:0] paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic pready;

  llg_magnetization_cell_update uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Shadow copy of the block's registers, used by the predictor.
  logic [1:0] face_sh;
  logic signed [47:0] kp_sh;
  logic signed [47:0] kd_sh;

  logic [3*DW-1:0] expected_mag[$];
  int errors;
  int ready_pct;     // chance in percent that the sink takes a word
  int gap_pct;       // chance in percent that the source pauses
  int sink_hold;
  int idle_cycles;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Clamp a wide value to signed 64 bits.
  function automatic s64_t clamp64(input s128_t v);
    if (v > s128_t'(64'sh7fff_ffff_ffff_ffff)) return 64'sh7fff_ffff_ffff_ffff;
    if (v < -s128_t'(64'sh7fff_ffff_ffff_ffff) - 1) return 64'sh8000_0000_0000_0000;
    return v[63:0];
  endfunction

  // Component i of a x b, rescaled by the fraction bits and clamped.
  function automatic s64_t cross_part(input s64_t a[3], input s64_t b[3], input int i);
    int j, k;
    s128_t aj, ak, bj, bk;
    j = (i + 1) % 3;
    k = (i + 2) % 3;
    aj = a[j]; ak = a[k]; bj = b[j]; bk = b[k];
    return clamp64((aj * bk - ak * bj) >>> FB);
  endfunction

  // Work out the updated magnetization for one cell word.
  function automatic logic [3*DW-1:0] llg_step(input logic [12*DW-1:0] word);
    s64_t m[3], h[3], p[3], q, s1, s2, delta;
    s128_t acc, kpw, kdw, pw, qw, sum;
    int f, t1, t2;
    logic [3*DW-1:0] r;
    f = (face_sh > FACE_Z) ? 2 : face_sh;
    t1 = (f == FACE_X) ? 1 : 0;
    t2 = (f == FACE_Z) ? 1 : 2;
    s1 = 0;
    s2 = 0;
    for (int n = 0; n < 3; n++) m[n] = $signed(word[DW*n +: DW]);
    for (int n = 0; n < 4; n++) begin
      s1 += $signed(word[DW*(4+n) +: DW]);
      s2 += $signed(word[DW*(8+n) +: DW]);
    end
    h[f] = $signed(word[DW*3 +: DW]);
    h[t1] = s1 >>> 2;
    h[t2] = s2 >>> 2;
    kpw = kp_sh;
    kdw = kd_sh;
    for (int i = 0; i < 3; i++) begin
      for (int n = 0; n < 3; n++) p[n] = cross_part(m, h, n);
      q = cross_part(m, p, i);
      pw = p[i];
      qw = q;
      acc = kpw * pw + kdw * qw;
      delta = clamp64(acc >>> 64);
      sum = s128_t'(m[i]) + s128_t'(delta);
      if (sum > 128'sd2147483647) m[i] = 64'sd2147483647;
      else if (sum < -128'sd2147483648) m[i] = -64'sd2147483648;
      else m[i] = sum[63:0];
      r[DW*i +: DW] = m[i][DW-1:0];
    end
    return r;
  endfunction

  // Random 32-bit sample: full range, extremes, or scaled-down magnitudes.
  function automatic logic [31:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return ($urandom_range(0, 1) != 0) ? 32'h7fff_ffff : 32'h8000_0000;
      1, 2: return $signed($urandom) >>> $urandom_range(8, 24);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [63:0] rand_coef();
    logic [63:0] v;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 4))
      0: v[47:0] = 48'h7fff_ffff_ffff;
      1: v[47:0] = 48'h8000_0000_0000;
      2: v[47:0] = $signed(v[47:0]) >>> $urandom_range(0, 40);
      default: ;
    endcase
    return v;
  endfunction

  // Register write: setup cycle, then access cycle; upper bits carry noise.
  task automatic reg_write(input logic [4:0] addr, input logic [63:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (addr)
      REG_FACE: face_sh = data[1:0];
      REG_KP: kp_sh = data[47:0];
      REG_KD: kd_sh = data[47:0];
      default: ;
    endcase
  endtask

  // Drain outstanding words so that registers change only while idle.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (expected_mag.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] f, input logic [63:0] kp, input logic [63:0] kd);
    wait_idle();
    reg_write(REG_FACE, {$urandom, $urandom} & ~64'h3 | f);
    reg_write(REG_KP, kp);
    reg_write(REG_KD, kd);
  endtask

  // Send one cell word; returns at the edge that accepts it.
  task automatic send_cell(input logic [12*DW-1:0] word);
    int gap;
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= word;
    forever begin
      @(negedge clk);
      if (s_axis_tready) break;
    end
    @(posedge clk);
    expected_mag.push_back(llg_step(word));
  endtask

  function automatic logic [12*DW-1:0] rand_cell();
    logic [12*DW-1:0] w;
    for (int n = 0; n < 12; n++) w[DW*n +: DW] = rand_sample();
    return w;
  endfunction

  task automatic test_directed();
    logic [12*DW-1:0] w;
    gap_pct = 0;
    ready_pct = 100;
    // Zero coefficients leave m untouched.
    configure(FACE_X, 64'd0, 64'd0);
    send_cell({12{32'h7fff_ffff}});
    send_cell({12{32'h8000_0000}});
    // Every face code, including the spare one, with extreme coefficients.
    for (int f = 0; f < 4; f++) begin
      configure(2'(f), 64'h0000_7fff_ffff_ffff, 64'hffff_8000_0000_0000);
      send_cell({12{32'h7fff_ffff}});
      send_cell({12{32'h8000_0000}});
      w = '0;
      w[DW*0 +: DW] = 32'h0001_0000;
      w[DW*3 +: DW] = 32'h7fff_ffff;
      for (int n = 4; n < 12; n++) w[DW*n +: DW] = (n % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
      send_cell(w);
      // Large m against large field drives the intermediates into saturation.
      for (int n = 0; n < 12; n++) w[DW*n +: DW] = (n % 3 == 1) ? 32'h8000_0000 : 32'h7fff_ffff;
      send_cell(w);
    end
  endtask

  task automatic test_random_phase(input int count, input int rpct, input int gpct);
    configure(2'($urandom_range(0, 3)), rand_coef(), rand_coef());
    ready_pct = rpct;
    gap_pct = gpct;
    repeat (count) send_cell(rand_cell());
  endtask

  // Sink back-pressure: random drops plus occasional long holds.
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_hold <= 0;
    end else if (sink_hold > 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= sink_hold - 1;
    end else if (ready_pct < 100 && $urandom_range(0, 99) == 0) begin
      m_axis_tready <= 1'b0;
      sink_hold <= $urandom_range(10, 40);
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) < ready_pct);
    end
  end

  // Check each output word against the oldest prediction.
  always @(negedge clk) begin
    logic [3*DW-1:0] exp_w;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_mag.size() == 0) begin
        $error("unexpected output word %h", m_axis_tdata);
        errors++;
      end else begin
        exp_w = expected_mag.pop_front();
        if (m_axis_tdata[0 +: DW] !== exp_w[0 +: DW]) begin
          $error("new_mag_x expected %h actual %h", exp_w[0 +: DW], m_axis_tdata[0 +: DW]);
          errors++;
        end
        if (m_axis_tdata[DW +: DW] !== exp_w[DW +: DW]) begin
          $error("new_mag_y expected %h actual %h", exp_w[DW +: DW], m_axis_tdata[DW +: DW]);
          errors++;
        end
        if (m_axis_tdata[2*DW +: DW] !== exp_w[2*DW +: DW]) begin
          $error("new_mag_z expected %h actual %h", exp_w[2*DW +: DW],
                 m_axis_tdata[2*DW +: DW]);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no word moves on either side.
  always @(negedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    errors = 0;
    idle_cycles = 0;
    ready_pct = 100;
    gap_pct = 0;
    face_sh = FACE_X;
    kp_sh = '0;
    kd_sh = '0;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random_phase(250, 100, 0);
    test_random_phase(250, 70, 30);
    test_random_phase(250, 95, 5);
    test_random_phase(250, 40, 60);
    test_random_phase(250, 85, 15);
    test_random_phase(250, 100, 20);
    test_random_phase(250, 60, 0);
    s_axis_tvalid <= 1'b0;
    while (expected_mag.size() != 0) @(posedge clk);
    repeat (LATENCY + 6) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
